[hw/rtl/ipr_pkg.sv]
// Package for the image pyramid reduce block: sizes, register map, reset values.
// Used by image_pyramid_reduce; no dependencies of its own.
package ipr_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
    localparam int CFG_BITS     = 11;
    localparam int OUT_BITS     = 12;
    localparam int OUT_TDATA    = 16;
    localparam int TAP_BITS     = PIXEL_BITS + 2;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } ipr_reg_t;

endpackage

[hw/rtl/image_pyramid_reduce.sv]
// image_pyramid_reduce: one Gaussian pyramid level, 3x3 (1,2,1)x(1,2,1) sum, 2:1 decimation.
// Result: valid in the cycle after accepting pixel (2y+1, 2x+1); other pixels give none.
// Throughput: one pixel per clock; input stalls only while a result waits on m_axis_tready.
// Line stores are read one column ahead, so each store needs one read and one write a cycle.
// Reset: position, pipeline and output valid cleared; width 640, height 480; stores not cleared.
// Depends on ipr_pkg and ipr_ram.
module image_pyramid_reduce
    import ipr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // APB configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // pixel words in
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [PIXEL_BITS-1:0]    s_axis_tdata,   // [7:0] pixel
    // reduced words out
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_TDATA-1:0]     m_axis_tdata,   // [11:0] reduced_value, [15:12] zero
    output logic                     m_axis_tlast    // frame_last
);

    function automatic logic [TAP_BITS-1:0] row_tap(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic [PIXEL_BITS-1:0] c
    );
        row_tap = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    logic [CFG_BITS-1:0]   width_reg, height_reg;
    logic [CFG_BITS-1:0]   w_eff, h_eff;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic                  cfg_wr, in_acc, emit, col_last, row_last, col_ge2, row_ge3;
    logic                  frame_last;

    logic [PIXEL_BITS-1:0] up_rd, mid_rd;
    logic [PIXEL_BITS-1:0] cur_m2_reg, cur_m1_reg;
    logic [PIXEL_BITS-1:0] up_m2_reg, up_m1_reg;
    logic [PIXEL_BITS-1:0] mid_m2_reg, mid_m1_reg;
    logic [PIXEL_BITS-1:0] top_a, top_b, top_c, mid_a, cur_a;
    logic [OUT_BITS-1:0]   sum;

    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_value_reg;
    logic                  out_last_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (ipr_reg_t'(paddr[2]))
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ipr_reg_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        priority if (width_reg < CFG_BITS'(2))
            w_eff = CFG_BITS'(2);
        else if (width_reg > CFG_BITS'(MAX_WIDTH))
            w_eff = CFG_BITS'(MAX_WIDTH);
        else
            w_eff = width_reg;

        priority if (height_reg < CFG_BITS'(2))
            h_eff = CFG_BITS'(2);
        else if (height_reg > CFG_BITS'(HEIGHT_LIMIT))
            h_eff = CFG_BITS'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    // ---------------- position ----------------
    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign emit     = row_reg[0] & col_reg[0];
    assign col_last = (CFG_BITS'(col_reg) == w_eff - CFG_BITS'(1));
    assign row_last = (CFG_BITS'(row_reg) == h_eff - CFG_BITS'(1));
    assign col_ge2  = |col_reg[COL_BITS-1:1];
    assign row_ge3  = |row_reg[ROW_BITS-1:1];
    // last output sits on the last odd row and column
    assign frame_last = (CFG_BITS'(row_reg) == {h_eff[CFG_BITS-1:1], 1'b0} - CFG_BITS'(1))
                      & (CFG_BITS'(col_reg) == {w_eff[CFG_BITS-1:1], 1'b0} - CFG_BITS'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
        else
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line stores ----------------
    // Read address runs at the next column so data for col_reg is ready when its pixel lands.
    // Upper store holds the last odd row, middle store the last even row.
    ipr_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (in_acc & row_reg[0]),
        .waddr (col_reg),
        .wdata (s_axis_tdata),
        .raddr (col_next),
        .rdata (up_rd)
    );

    ipr_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .clk   (clk),
        .we    (in_acc & ~row_reg[0]),
        .waddr (col_reg),
        .wdata (s_axis_tdata),
        .raddr (col_next),
        .rdata (mid_rd)
    );

    // columns c-2 and c-1 of each row in the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_m2_reg <= '0;
            cur_m1_reg <= '0;
            up_m2_reg  <= '0;
            up_m1_reg  <= '0;
            mid_m2_reg <= '0;
            mid_m1_reg <= '0;
        end
        else if (in_acc)
        begin
            cur_m2_reg <= cur_m1_reg;
            cur_m1_reg <= s_axis_tdata;
            up_m2_reg  <= up_m1_reg;
            up_m1_reg  <= up_rd;
            mid_m2_reg <= mid_m1_reg;
            mid_m1_reg <= mid_rd;
        end
    end

    // ---------------- filter ----------------
    // left border repeats column 0; top border (output row 0) repeats the even row
    always_comb
    begin
        if (row_ge3)
        begin
            top_a = col_ge2 ? up_m2_reg : up_m1_reg;
            top_b = up_m1_reg;
            top_c = up_rd;
        end
        else
        begin
            top_a = col_ge2 ? mid_m2_reg : mid_m1_reg;
            top_b = mid_m1_reg;
            top_c = mid_rd;
        end
        mid_a = col_ge2 ? mid_m2_reg : mid_m1_reg;
        cur_a = col_ge2 ? cur_m2_reg : cur_m1_reg;
        sum = {2'b00, row_tap(top_a, top_b, top_c)}
            + {1'b0, row_tap(mid_a, mid_m1_reg, mid_rd), 1'b0}
            + {2'b00, row_tap(cur_a, cur_m1_reg, s_axis_tdata)};
    end

    // ---------------- output register ----------------
    assign s_axis_tready = ~out_valid_reg | m_axis_tready | ~emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc & emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc & emit)
        begin
            out_value_reg <= sum;
            out_last_reg  <= frame_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA'(out_value_reg);
    assign m_axis_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_stall_only_on_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with no pending result");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && emit) |=> m_axis_tvalid)
        else $error("result not presented after odd row/column pixel");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CFG_BITS'(col_reg) < w_eff)
        else $error("column position beyond image width");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && col_last && row_last) |=> (col_reg == '0 && row_reg == '0))
        else $error("position did not wrap at frame end");

endmodule

[hw/rtl/ipr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; sized by WIDTH and DEPTH.
module ipr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
